@@ src/bfsf_pkg.sv @@
package bfsf_pkg;

  localparam int WORD_W       = 64;
  localparam int SEED_W       = 8;
  localparam int SEED_SLOTS   = 8;
  localparam int BYTE_W       = 8;
  localparam int SET_SIZE_W   = 13;
  localparam int HASH_COUNT_W = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int ACTION_W     = 2;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_TEST   = 2'd1;
  localparam action_t ACT_CLEAR  = 2'd2;
  localparam action_t ACT_NONE   = 2'd3;

  localparam cfg_idx_t REG_SET_SIZE   = 2'd0;
  localparam cfg_idx_t REG_HASH_COUNT = 2'd1;
  localparam cfg_idx_t REG_SEED_PACK  = 2'd2;

  localparam logic [SET_SIZE_W-1:0]   SET_SIZE_RST   = 13'd4096;
  localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST = 4'd4;

endpackage

@@ src/bfsf_ram.sv @@
module bfsf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/bfsf_mod.sv @@
module bfsf_mod #(
  parameter int STORE_BITS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  bfsf_pkg::word_t               dividend,
  input  logic [$clog2(STORE_BITS):0]   divisor,
  output logic                          done,
  output logic [$clog2(STORE_BITS)-1:0] rem_out
);
  import bfsf_pkg::*;

  localparam int IW = $clog2(STORE_BITS);
  localparam int SW = IW + 1;
  localparam int CW = $clog2(WORD_W + 1);

  logic [SW-1:0] rem;
  word_t         shreg;
  logic [CW-1:0] cnt;
  logic          running;
  logic [SW:0]   trial;
  logic [SW:0]   dvs_ext;

  assign trial   = {rem, shreg[WORD_W-1]};
  assign dvs_ext = {1'b0, divisor};
  assign rem_out = rem[IW-1:0];

  // one quotient bit a cycle, restoring form
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      if (start) begin
        running <= 1'b1;
        done    <= 1'b0;
        cnt     <= '0;
        rem     <= '0;
        shreg   <= dividend;
      end else if (running) begin
        shreg <= {shreg[WORD_W-2:0], 1'b0};
        if (trial >= dvs_ext) begin
          rem <= SW'(trial - dvs_ext);
        end else begin
          rem <= trial[SW-1:0];
        end
        cnt  <= cnt + 1'b1;
        done <= (cnt == CW'(WORD_W - 1));
        if (cnt == CW'(WORD_W - 1)) begin
          running <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

@@ src/bloom_filter_string_fold_core.sv @@
// Bloom filter over byte strings, folded in fixed chunks by up to MAX_HASHES hashes.
// Input: pulse start with action, data_byte and last; a word is taken when start is
// high and busy is low. Insert and test bytes fold into the per-hash sums; clear
// zeroes the bit store and drops any partial string; action 3 is ignored.
// Output: on the final byte of a test string, done pulses for one cycle with member.
// The receiver cannot stall; the result is simply presented for that one cycle.
// Configuration: cfg_we, cfg_index, cfg_data write one of set_size, hash_count,
// seed_pack, picked by cfg_index; write them only while busy is low.
// Per byte: each hash in turn gets pos multiplies by its seed on one shared
// 64x8 multiplier, then one add and one fold step, pos being the byte's place
// in its chunk. A last byte then takes a finish step, and per active hash a
// launch step, a bit-serial modulo and a store step (a read of the store for
// a test). Clear writes zeros over the store, one store bit a cycle.
// After reset the same clearing pass runs with busy high.
module bloom_filter_string_fold_core #(
  parameter int STORE_BITS  = 4096,
  parameter int MAX_HASHES  = 8,
  parameter int CHUNK_BYTES = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  bfsf_pkg::action_t                    action,
  input  logic [bfsf_pkg::BYTE_W-1:0]          data_byte,
  input  logic                                 last,
  output logic                                 done,
  output logic                                 member,
  input  logic                                 cfg_we,
  input  bfsf_pkg::cfg_idx_t                   cfg_index,
  input  bfsf_pkg::word_t                      cfg_data
);
  import bfsf_pkg::*;

  localparam int IW  = $clog2(STORE_BITS);
  localparam int SW  = IW + 1;
  localparam int HW  = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int HCW = $clog2(MAX_HASHES + 1);
  localparam int PW  = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_MUL, S_FOLD, S_FIN, S_MOD_GO, S_MOD_WAIT, S_ACC, S_RD
  } state_t;

  state_t state;

  logic [SET_SIZE_W-1:0]   set_size;
  logic [HASH_COUNT_W-1:0] hash_count;
  word_t                   seed_pack;

  word_t         sums     [MAX_HASHES];
  word_t         partials [MAX_HASHES];
  logic [PW-1:0] pos;
  logic [PW-1:0] k;
  logic [HW-1:0] hi;
  logic [HCW-1:0] hcnt;
  word_t         acc;
  word_t         sb;
  logic          str_last;
  action_t       str_act;
  logic          memb;
  logic [IW-1:0] clr_addr;

  logic [SW-1:0]  size_eff;
  logic [HCW-1:0] active;
  logic [SEED_W-1:0] seed_sel;
  logic           pos_last;
  logic           mod_start;
  logic           mod_done;
  logic [IW-1:0]  mod_rem;
  word_t          mod_dvd;
  logic           ram_we;
  logic [IW-1:0]  ram_waddr;
  logic           ram_wdata;
  logic [IW-1:0]  ram_raddr;
  logic           ram_rdata;
  logic [HW-1:0]  hsel;
  logic           hcnt_end;

  always_comb begin
    if (set_size == '0) begin
      size_eff = SW'(1);
    end else if (32'(set_size) > STORE_BITS) begin
      size_eff = SW'(STORE_BITS);
    end else begin
      size_eff = SW'(set_size);
    end
    if (32'(hash_count) > MAX_HASHES) begin
      active = HCW'(MAX_HASHES);
    end else begin
      active = HCW'(hash_count);
    end
  end

  // hashes beyond the packed slots run with seed zero
  always_comb begin
    seed_sel = '0;
    for (int j = 0; j < SEED_SLOTS; j++) begin
      if (32'(hi) == j) begin
        seed_sel = seed_pack[SEED_W*j +: SEED_W];
      end
    end
  end

  assign pos_last  = (32'(pos) == CHUNK_BYTES - 1);
  assign hsel      = hcnt[HW-1:0];
  assign hcnt_end  = (hcnt + 1'b1 == active);
  assign mod_start = (state == S_MOD_GO);
  assign mod_dvd   = sums[hsel] + 1'b1;
  assign busy      = (state != S_IDLE);

  assign ram_we    = (state == S_CLR) || (state == S_ACC && str_act == ACT_INSERT);
  assign ram_waddr = (state == S_CLR) ? clr_addr : mod_rem;
  assign ram_wdata = (state != S_CLR);
  assign ram_raddr = mod_rem;

  bfsf_mod #(.STORE_BITS(STORE_BITS)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (size_eff),
    .done     (mod_done),
    .rem_out  (mod_rem)
  );

  bfsf_ram #(.WIDTH(1), .DEPTH(STORE_BITS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      done       <= 1'b0;
      member     <= 1'b0;
      set_size   <= SET_SIZE_RST;
      hash_count <= HASH_COUNT_RST;
      seed_pack  <= '0;
      pos        <= '0;
      for (int i = 0; i < MAX_HASHES; i++) begin
        sums[i]     <= '0;
        partials[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SET_SIZE:   set_size   <= cfg_data[SET_SIZE_W-1:0];
          REG_HASH_COUNT: hash_count <= cfg_data[HASH_COUNT_W-1:0];
          REG_SEED_PACK:  seed_pack  <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          // drop the strobe of the word just finished
          done <= 1'b0;
          if (start) begin
            sb       <= {{(WORD_W-BYTE_W){data_byte[BYTE_W-1]}}, data_byte};
            acc      <= {{(WORD_W-BYTE_W){data_byte[BYTE_W-1]}}, data_byte};
            str_act  <= action;
            str_last <= last;
            hi       <= '0;
            k        <= '0;
            unique case (action) inside
              ACT_INSERT, ACT_TEST: state <= S_MUL;
              ACT_CLEAR: begin
                clr_addr <= '0;
                pos      <= '0;
                for (int i = 0; i < MAX_HASHES; i++) begin
                  sums[i]     <= '0;
                  partials[i] <= '0;
                end
                state <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == STORE_BITS - 1) begin
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          if (k != pos) begin
            acc <= acc * WORD_W'(seed_sel);
            k   <= k + 1'b1;
          end else begin
            partials[hi] <= partials[hi] + acc;
            state        <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (pos_last) begin
            sums[hi]     <= sums[hi] + partials[hi];
            partials[hi] <= '0;
          end
          if (32'(hi) == MAX_HASHES - 1) begin
            pos   <= pos_last ? '0 : pos + 1'b1;
            state <= str_last ? S_FIN : S_IDLE;
          end else begin
            hi    <= hi + 1'b1;
            acc   <= sb;
            k     <= '0;
            state <= S_MUL;
          end
        end
        S_FIN: begin
          hcnt <= '0;
          memb <= 1'b1;
          if (active == '0) begin
            done   <= (str_act == ACT_TEST);
            member <= 1'b1;
            pos    <= '0;
            for (int i = 0; i < MAX_HASHES; i++) begin
              sums[i]     <= '0;
              partials[i] <= '0;
            end
            state <= S_IDLE;
          end else begin
            state <= S_MOD_GO;
          end
        end
        S_MOD_GO: state <= S_MOD_WAIT;
        S_MOD_WAIT: begin
          if (mod_done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (str_act == ACT_TEST) begin
            state <= S_RD;
          end else if (hcnt_end) begin
            pos <= '0;
            for (int i = 0; i < MAX_HASHES; i++) begin
              sums[i]     <= '0;
              partials[i] <= '0;
            end
            state <= S_IDLE;
          end else begin
            hcnt  <= hcnt + 1'b1;
            state <= S_MOD_GO;
          end
        end
        S_RD: begin
          memb <= memb & ram_rdata;
          if (hcnt_end) begin
            done   <= 1'b1;
            member <= memb & ram_rdata;
            pos    <= '0;
            for (int i = 0; i < MAX_HASHES; i++) begin
              sums[i]     <= '0;
              partials[i] <= '0;
            end
            state <= S_IDLE;
          end else begin
            hcnt  <= hcnt + 1'b1;
            state <= S_MOD_GO;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/bfsf_checker.sv @@
module bfsf_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input bfsf_pkg::action_t  action,
  input logic               last,
  input logic               done
);
  import bfsf_pkg::*;

  // reset starts the clearing pass
  a_rst_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result without preceding work");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACT_TEST || action == ACT_INSERT)) |=> (busy && !done))
    else $error("byte word finished without work");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_CLEAR && last) |=> !done)
    else $error("clear gave a result");

endmodule

bind bloom_filter_string_fold_core bfsf_checker u_bfsf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .action (action),
  .last   (last),
  .done   (done)
);

@@ bench/tb_bloom_filter_string_fold_core.sv @@
`timescale 1ns / 100ps

module tb_bloom_filter_string_fold_core;
  import bfsf_pkg::*;

  localparam int STORE_BITS  = 4096;
  localparam int MAX_HASHES  = 8;
  localparam int CHUNK_BYTES = 4;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 800;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  action_t               action;
  logic [BYTE_W-1:0]     data_byte;
  logic                  last;
  logic                  done;
  logic                  member;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  word_t                 cfg_data;

  // model copy of the filter
  bit                    store_bits [STORE_BITS];
  word_t                 fold_sum   [MAX_HASHES];
  word_t                 fold_part  [MAX_HASHES];
  int unsigned           chunk_pos;
  logic [SET_SIZE_W-1:0] cur_size;
  logic [HASH_COUNT_W-1:0] cur_count;
  word_t                 cur_seeds;

  bit                    member_q [$];
  int unsigned           err_count;
  int unsigned           cycle_count;
  int unsigned           gap_pct;
  logic [7:0]            lib [16][$];

  bloom_filter_string_fold_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .data_byte(data_byte), .last(last), .done(done), .member(member),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (member_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        bit want;
        want = member_q.pop_front();
        if (member !== want)
          report($sformatf("member %b, expected %b", member, want));
      end
    end
  end

  function automatic void reset_string();
    for (int i = 0; i < MAX_HASHES; i++) begin
      fold_sum[i]  = '0;
      fold_part[i] = '0;
    end
    chunk_pos = 0;
  endfunction

  function automatic word_t seed_power(input word_t s, input int unsigned e);
    word_t r;
    r = 64'd1;
    for (int k = 0; k < e; k++) r = r * s;
    return r;
  endfunction

  // fold one accepted word into the model; queue a membership answer if one is due
  function automatic void predict_word(input action_t a, input logic [7:0] b, input logic l);
    word_t sb;
    int unsigned sz;
    int unsigned nh;
    word_t idx;
    bit hit;
    if (a == ACT_NONE) return;
    if (a == ACT_CLEAR) begin
      for (int i = 0; i < STORE_BITS; i++) store_bits[i] = 1'b0;
      reset_string();
      return;
    end
    sb = {{56{b[7]}}, b};
    for (int i = 0; i < MAX_HASHES; i++) begin
      fold_part[i] += sb * seed_power({56'd0, cur_seeds[8*i +: 8]}, chunk_pos);
      if (chunk_pos == CHUNK_BYTES - 1) begin
        fold_sum[i] += fold_part[i];
        fold_part[i] = '0;
      end
    end
    chunk_pos = (chunk_pos == CHUNK_BYTES - 1) ? 0 : chunk_pos + 1;
    if (!l) return;
    sz = cur_size;
    if (sz == 0) sz = 1;
    if (sz > STORE_BITS) sz = STORE_BITS;
    nh = cur_count;
    if (nh > MAX_HASHES) nh = MAX_HASHES;
    hit = 1'b1;
    for (int i = 0; i < nh; i++) begin
      idx = (fold_sum[i] + 64'd1) % sz;
      if (a == ACT_INSERT) store_bits[idx] = 1'b1;
      else if (!store_bits[idx]) hit = 1'b0;
    end
    reset_string();
    if (a == ACT_TEST) member_q = {member_q, hit};
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input action_t a, input logic [7:0] b, input logic l);
    if (busy) begin
      start = 1'b0;
      while (busy) @(negedge clk);
    end
    start     = 1'b1;
    action    = a;
    data_byte = b;
    last      = l;
    predict_word(a, b, l);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    if ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    @(negedge clk);
    while (member_q.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input word_t val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      REG_SET_SIZE:   cur_size  = val[SET_SIZE_W-1:0];
      REG_HASH_COUNT: cur_count = val[HASH_COUNT_W-1:0];
      REG_SEED_PACK:  cur_seeds = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input word_t sz, input word_t nh, input word_t seeds);
    drain();
    write_reg(REG_SET_SIZE, sz);
    write_reg(REG_HASH_COUNT, nh);
    write_reg(REG_SEED_PACK, seeds);
  endtask

  task automatic send_string(input action_t a, input logic [7:0] s [$]);
    for (int i = 0; i < s.size(); i++) begin
      send_word(a, s[i], i == s.size() - 1);
      idle_gap();
    end
  endtask

  task automatic test_directed();
    logic [7:0] s [$];
    gap_pct = 0;
    set_config(64'd4096, 64'd4, 64'hFF80_7F01_0203_0407);
    s = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h12};
    send_string(ACT_INSERT, s);
    send_string(ACT_TEST, s);
    s = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h80};
    send_string(ACT_TEST, s);
    // a string too short for one chunk hashes to one
    send_word(ACT_TEST, 8'h55, 1'b1);
    // mixed actions: the final byte decides
    send_word(ACT_TEST, 8'h00, 1'b0);
    send_word(ACT_INSERT, 8'h7F, 1'b0);
    send_word(ACT_NONE, 8'hAA, 1'b1);
    send_word(ACT_TEST, 8'h80, 1'b0);
    send_word(ACT_INSERT, 8'hFF, 1'b1);
    // clear drops the partial string and the store
    send_word(ACT_INSERT, 8'h01, 1'b0);
    send_word(ACT_CLEAR, 8'hFF, 1'b1);
    send_word(ACT_TEST, 8'h55, 1'b1);
    set_config(64'd0, 64'd0, 64'h0);
    send_word(ACT_INSERT, 8'h01, 1'b1);
    send_word(ACT_TEST, 8'hFE, 1'b1);
    set_config(64'h1FFF, 64'hF, 64'hFFFF_FFFF_FFFF_FFFF);
    s = '{8'h01, 8'h02, 8'h03, 8'h04};
    send_string(ACT_INSERT, s);
    send_string(ACT_TEST, s);
  endtask

  task automatic run_random(input int unsigned n_items);
    logic [7:0] s [$];
    int unsigned sent;
    int unsigned slot;
    int unsigned len;
    int unsigned pick;
    action_t a;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_word(ACT_NONE, 8'($urandom), 1'($urandom));
        idle_gap();
      end else if (pick < 4) begin
        send_word(ACT_CLEAR, 8'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 10) begin
        // broken string: random actions mixed
        len = $urandom_range(1, 7);
        for (int i = 0; i < len; i++) begin
          a = $urandom_range(1) ? ACT_TEST : ACT_INSERT;
          send_word(a, 8'($urandom), i == len - 1);
          idle_gap();
        end
        sent += len;
      end else begin
        slot = $urandom_range(15);
        if (lib[slot].size() == 0 || $urandom_range(2) == 0) begin
          len = $urandom_range(1, 12);
          s.delete();
          for (int i = 0; i < len; i++) s = {s, 8'($urandom)};
          lib[slot] = s;
        end
        a = $urandom_range(1) ? ACT_INSERT : ACT_TEST;
        send_string(a, lib[slot]);
        sent += lib[slot].size();
      end
    end
  endtask

  task automatic test_no_idle();
    gap_pct = 0;
    set_config(64'd4096, 64'd8, {$urandom, $urandom});
    run_random(300);
  endtask

  task automatic test_sender_sparse();
    gap_pct = 88;
    set_config(64'd61, 64'd2, {$urandom, $urandom});
    run_random(300);
  endtask

  task automatic test_sender_light();
    gap_pct = 9;
    set_config(64'd1, 64'd1, {$urandom, $urandom});
    run_random(150);
    set_config(64'd5000, 64'd12, 64'hFFFF_FFFF_FFFF_FFFF);
    run_random(200);
  endtask

  task automatic test_random_configs();
    gap_pct = 30;
    repeat (6) begin
      set_config(64'($urandom_range(1, 300)), 64'($urandom_range(0, 15)),
                 {$urandom, $urandom});
      run_random(50);
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    action      = ACT_NONE;
    data_byte   = '0;
    last        = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_SET_SIZE;
    cfg_data    = '0;
    err_count   = 0;
    cycle_count = 0;
    gap_pct     = 0;
    cur_size    = SET_SIZE_RST;
    cur_count   = HASH_COUNT_RST;
    cur_seeds   = '0;
    for (int i = 0; i < STORE_BITS; i++) store_bits[i] = 1'b0;
    reset_string();
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_no_idle();
    test_sender_sparse();
    test_sender_light();
    test_random_configs();
    drain();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
